[sv/kfrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfrb_pkg
// Types, constants and status codes shared by the keyframe ring frame buffer.
// ----------------------------------------------------------------------------
package kfrb_pkg;

  localparam int SLOT_COUNT_DEF   = 1024;
  localparam int SLOT_BYTES_DEF   = 1024;
  localparam int READER_COUNT_DEF = 4;

  localparam int FLEN_W   = 21;
  localparam int FNUM_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_READ     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WM_STORE  = 2'd0,
    WM_DROP   = 2'd1,
    WM_REJECT = 2'd2
  } wmode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
  } cmd_t;

endpackage

[sv/kfrb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfrb_ctrl
// Sequencer: capture a transaction, fetch tags and data, execute, present.
// ----------------------------------------------------------------------------
module kfrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output kfrb_pkg::cmd_t    cmd
);

  kfrb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kfrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kfrb_pkg::S_IDLE:  if (in_tvalid) state_nxt = kfrb_pkg::S_FETCH;
      kfrb_pkg::S_FETCH: state_nxt = kfrb_pkg::S_EXEC;
      kfrb_pkg::S_EXEC:  state_nxt = kfrb_pkg::S_OUT;
      kfrb_pkg::S_OUT:   if (out_tready) state_nxt = kfrb_pkg::S_IDLE;
      default:           state_nxt = kfrb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd         = '0;
    unique case (state_r)
      kfrb_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      kfrb_pkg::S_FETCH: cmd.fetch = 1'b1;
      kfrb_pkg::S_EXEC:  cmd.exec = 1'b1;
      kfrb_pkg::S_OUT:   out_tvalid = 1'b1;
      default: ;
    endcase
  end

endmodule

[sv/kfrb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfrb_dp
// Datapath: slot byte memory, slot tag memory, writer and reader contexts.
// ----------------------------------------------------------------------------
module kfrb_dp #(
  parameter int SLOT_COUNT   = kfrb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES   = kfrb_pkg::SLOT_BYTES_DEF,
  parameter int READER_COUNT = kfrb_pkg::READER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kfrb_pkg::cmd_t              cmd,
  input  logic                        in_func,
  input  logic [1:0]                  in_rid,
  input  logic [7:0]                  in_data,
  input  logic                        in_key,
  input  logic [kfrb_pkg::FLEN_W-1:0] in_flen,
  output logic [2:0]                  o_status,
  output logic [7:0]                  o_data,
  output logic [kfrb_pkg::FLEN_W-1:0] o_flen,
  output logic                        o_key,
  output logic [kfrb_pkg::FNUM_W-1:0] o_fnum,
  output logic                        o_last
);

  localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OW  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int OCW = $clog2(SLOT_BYTES + 1);
  localparam int RW  = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
  localparam int FW  = kfrb_pkg::FLEN_W;
  localparam int NW  = kfrb_pkg::FNUM_W;
  localparam int TW  = 1 + NW + FW + OCW;
  localparam int MEM_DEPTH = SLOT_COUNT * (1 << OW);
  localparam longint CAP = longint'(SLOT_COUNT) * longint'(SLOT_BYTES);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
  localparam logic [SW:0]   FILL_FULL = (SW+1)'(SLOT_COUNT);

  typedef struct packed {
    logic           head;
    logic [NW-1:0]  fnum;
    logic [FW-1:0]  flen;
    logic [OCW-1:0] plen;
  } tag_t;

  // memories
  logic [7:0]    mem_byte [MEM_DEPTH];
  logic [TW-1:0] mem_tag  [SLOT_COUNT];
  logic          mem_key  [SLOT_COUNT];
  // slots are first written in ring order, so slots below the fill count
  // hold tags and the rest read as zero
  logic [SW:0]   fill_r;

  // captured transaction
  logic          func_r, key_in_r;
  logic [1:0]    rid_r;
  logic [7:0]    data_r;
  logic [FW-1:0] flen_in_r;

  // writer
  logic          w_act_r, w_key_r;
  kfrb_pkg::wmode_t w_mode_r;
  logic [FW-1:0] w_len_r, w_cnt_r;
  logic [SW-1:0] w_head_r, wslot_r, pub_r, key_slot_r;
  logic [OCW-1:0] w_off_r;
  logic          key_valid_r;
  logic [NW-1:0] fcnt_r;

  // readers
  logic [SW-1:0]  r_slot_r  [READER_COUNT];
  logic [READER_COUNT-1:0] r_valid_r, r_act_r, r_key_r;
  logic [NW-1:0]  r_last_r  [READER_COUNT];
  logic [FW-1:0]  r_len_r   [READER_COUNT];
  logic [FW-1:0]  r_cnt_r   [READER_COUNT];
  logic [OCW-1:0] r_off_r   [READER_COUNT];

  // fetched values: at the reader's own slot and at the key slot
  logic [TW-1:0] tagc_q_r, tagk_q_r;
  logic          keyc_q_r, keyk_q_r;
  logic          vc_r, vk_r;
  logic [7:0]    bytec_q_r, bytek_q_r;

  logic          rid_ok;
  logic [RW-1:0] ri;
  tag_t          ftag;
  logic          r_start, r_jump, sel_key;
  logic [SW-1:0] r_slot_cur, rd_slot_nxt;
  logic [OCW-1:0] roff;

  assign rid_ok = (32'(rid_r) < READER_COUNT);
  assign ri     = RW'(rid_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= in_func;
      rid_r     <= in_rid;
      data_r    <= in_data;
      key_in_r  <= in_key;
      flen_in_r <= in_flen;
    end
  end

  assign r_slot_cur = r_slot_r[ri];
  assign r_start    = rid_ok && !r_act_r[ri];
  assign roff       = r_start ? '0 : r_off_r[ri];

  // both candidate slots are read in the fetch cycle, the choice is made in exec
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      tagc_q_r  <= mem_tag[r_slot_cur];
      tagk_q_r  <= mem_tag[key_slot_r];
      keyc_q_r  <= mem_key[r_slot_cur];
      keyk_q_r  <= mem_key[key_slot_r];
      vc_r      <= ({1'b0, r_slot_cur} < fill_r);
      vk_r      <= ({1'b0, key_slot_r} < fill_r);
      bytec_q_r <= mem_byte[{r_slot_cur, OW'(roff)}];
      bytek_q_r <= mem_byte[{key_slot_r, {OW{1'b0}}}];
    end
  end

  assign ftag        = vc_r ? tag_t'(tagc_q_r) : '0;
  assign r_jump      = !r_valid_r[ri] || ((r_last_r[ri] + NW'(1)) != ftag.fnum);
  assign sel_key     = r_start && r_jump;
  assign rd_slot_nxt = sel_key ? key_slot_r : r_slot_cur;

  tag_t       etag;
  logic       ekey;
  logic [7:0] ebyte;
  assign etag  = sel_key ? (vk_r ? tag_t'(tagk_q_r) : '0) : ftag;
  assign ekey  = sel_key ? (vk_r & keyk_q_r) : (vc_r & keyc_q_r);
  assign ebyte = sel_key ? bytek_q_r : bytec_q_r;

  // writer combinational
  logic           w_start;
  kfrb_pkg::wmode_t wm;
  logic [FW-1:0]  wlen, wcnt1;
  logic           wkey;
  logic [OCW-1:0] woff;
  logic [FW-1:0]  wrem;
  tag_t           wtag;
  logic           w_new;
  assign w_start = !w_act_r;
  assign wlen = w_start ? flen_in_r : w_len_r;
  assign wkey = w_start ? key_in_r : w_key_r;
  assign wcnt1 = (w_start ? '0 : w_cnt_r) + FW'(1);
  assign woff  = w_start ? '0 : w_off_r;
  assign wrem  = wlen - (w_start ? '0 : w_cnt_r);
  assign w_new = ({1'b0, wslot_r} >= fill_r);
  always_comb begin
    if (w_start) begin
      if (64'(flen_in_r) > 64'(CAP)) wm = kfrb_pkg::WM_REJECT;
      else if (!key_in_r && !key_valid_r) wm = kfrb_pkg::WM_DROP;
      else wm = kfrb_pkg::WM_STORE;
    end else begin
      wm = w_mode_r;
    end
    wtag.head = (w_start || w_cnt_r == '0);
    wtag.fnum = fcnt_r;
    wtag.flen = wlen;
    wtag.plen = (32'(wrem) < SLOT_BYTES) ? OCW'(wrem) : OCW'(SLOT_BYTES);
  end

  logic w_store;
  assign w_store = cmd.exec && !func_r && !(w_start && flen_in_r == '0)
                   && wm == kfrb_pkg::WM_STORE;

  always_ff @(posedge clk) begin
    if (w_store) begin
      mem_byte[{wslot_r, OW'(woff)}] <= data_r;
      if (woff == '0) begin
        mem_tag[wslot_r] <= wtag;
        // key bit only changes at the frame head, a fresh slot starts at zero
        if (wtag.head || w_new) mem_key[wslot_r] <= wtag.head & wkey;
      end
    end
  end

  logic [SW-1:0] wnext, rnext;
  assign wnext = (wslot_r == SLOT_LAST) ? '0 : wslot_r + SW'(1);
  assign rnext = (rd_slot_nxt == SLOT_LAST) ? '0 : rd_slot_nxt + SW'(1);

  logic [FW-1:0] rlen, rcnt1;
  logic [OCW-1:0] roff1;
  logic          rkey;
  logic [NW-1:0] rfnum;
  tag_t          cur_tag;
  assign cur_tag = etag;
  assign rlen  = r_start ? etag.flen : r_len_r[ri];
  assign rkey  = r_start ? ekey : r_key_r[ri];
  assign rfnum = r_start ? etag.fnum : r_last_r[ri];
  assign rcnt1 = (r_start ? '0 : r_cnt_r[ri]) + FW'(1);
  assign roff1 = roff + OCW'(1);

  logic r_empty;
  assign r_empty = !rid_ok || (r_start && (!key_valid_r ||
                   (r_valid_r[ri] && r_slot_cur == pub_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      w_act_r     <= 1'b0;
      wslot_r     <= '0;
      pub_r       <= '0;
      key_slot_r  <= '0;
      key_valid_r <= 1'b0;
      fcnt_r      <= '0;
      r_valid_r   <= '0;
      r_act_r     <= '0;
      for (int i = 0; i < READER_COUNT; i++) begin
        r_slot_r[i] <= '0;
        r_last_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (!func_r) begin
        if (!(w_start && flen_in_r == '0)) begin
          w_act_r  <= (wcnt1 < wlen);
          w_mode_r <= wm;
          w_len_r  <= wlen;
          w_key_r  <= wkey;
          w_cnt_r  <= wcnt1;
          if (w_start) w_head_r <= wslot_r;
          if (wm == kfrb_pkg::WM_STORE) begin
            if (woff == '0 && fill_r != FILL_FULL) fill_r <= fill_r + (SW+1)'(1);
            if (32'(woff) + 1 >= SLOT_BYTES || wcnt1 >= wlen) begin
              wslot_r <= wnext;
              w_off_r <= '0;
            end else begin
              w_off_r <= woff + OCW'(1);
            end
            if (wcnt1 >= wlen) begin
              pub_r  <= wnext;
              fcnt_r <= fcnt_r + NW'(1);
              if (wkey) begin
                key_slot_r  <= w_start ? wslot_r : w_head_r;
                key_valid_r <= 1'b1;
              end
            end
          end
        end
      end else if (!r_empty) begin
        r_valid_r[ri] <= 1'b1;
        r_act_r[ri]   <= (rcnt1 < rlen);
        r_len_r[ri]   <= rlen;
        r_key_r[ri]   <= rkey;
        r_last_r[ri]  <= rfnum;
        r_cnt_r[ri]   <= rcnt1;
        if (roff1 >= cur_tag.plen || 32'(roff1) >= SLOT_BYTES || rcnt1 >= rlen) begin
          r_slot_r[ri] <= rnext;
          r_off_r[ri]  <= '0;
        end else begin
          r_slot_r[ri] <= rd_slot_nxt;
          r_off_r[ri]  <= roff1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      o_data <= '0;
      o_flen <= '0;
      o_key  <= 1'b0;
      o_fnum <= '0;
      o_last <= 1'b0;
      if (!func_r) begin
        if (w_start && flen_in_r == '0) begin
          o_status <= kfrb_pkg::ST_REJECTED;
          o_last   <= 1'b1;
        end else begin
          o_last <= (wcnt1 >= wlen);
          case (wm)
            kfrb_pkg::WM_REJECT: o_status <= kfrb_pkg::ST_REJECTED;
            kfrb_pkg::WM_DROP:   o_status <= kfrb_pkg::ST_DROPPED;
            default:             o_status <= kfrb_pkg::ST_STORED;
          endcase
        end
      end else if (r_empty) begin
        o_status <= kfrb_pkg::ST_EMPTY;
      end else begin
        o_status <= kfrb_pkg::ST_READ;
        o_data   <= ebyte;
        o_flen   <= rlen;
        o_key    <= rkey;
        o_fnum   <= rfnum;
        o_last   <= (rcnt1 >= rlen);
      end
    end
  end

endmodule

[sv/keyframe_ring_frame_buffer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_ring_frame_buffer_top
// Ring of packet slots holding numbered frames, one byte per transaction.
// ----------------------------------------------------------------------------
// latency: the result is registered in the execute state and presented as a
//   result transaction in the present state that follows
// throughput: a new transaction is accepted only after the previous result is
//   taken, set by the capture/fetch/execute/present sequence of the controller
// reset: rst_n synchronous; clears pointers, reader contexts and the slot fill
//   count at once, no clearing pass
module keyframe_ring_frame_buffer_top #(
  parameter int SLOT_COUNT   = kfrb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES   = kfrb_pkg::SLOT_BYTES_DEF,
  parameter int READER_COUNT = kfrb_pkg::READER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func, reader_id, data_in, key_frame, frame_length
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, data_out, out_frame_length, out_key,
                                  // out_frame_number
  output logic        out_tlast
);

  kfrb_pkg::cmd_t cmd;
  logic [2:0]  st;
  logic [7:0]  dat;
  logic [20:0] fl;
  logic        ky;
  logic [31:0] fn;

  kfrb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd)
  );

  kfrb_dp #(
    .SLOT_COUNT(SLOT_COUNT), .SLOT_BYTES(SLOT_BYTES), .READER_COUNT(READER_COUNT)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_func(in_tdata[0]), .in_rid(in_tdata[2:1]), .in_data(in_tdata[10:3]),
    .in_key(in_tdata[11]), .in_flen(in_tdata[32:12]),
    .o_status(st), .o_data(dat), .o_flen(fl), .o_key(ky), .o_fnum(fn),
    .o_last(out_tlast)
  );

  assign out_tdata = {7'b0, fn, ky, fl, dat, st};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("accept while busy");
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready)) else $error("result and input overlap");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= 3'd4)) else $error("bad status");
`endif

endmodule

[verif/tb_keyframe_ring_frame_buffer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_ring_frame_buffer_top
// Self-checking bench for the keyframe ring frame buffer: a directed table
// of frame writes and reads, then random frame traffic over four readers.
// Every result transaction is checked against an in-bench ring model or a table row.
// ----------------------------------------------------------------------------
module tb_keyframe_ring_frame_buffer_top;

  localparam int NSLOT  = 1024;
  localparam int NBYTE  = 1024;
  localparam int NREAD  = 4;
  localparam int LIMIT  = 600000;
  localparam bit FN_WR  = 1'b0;
  localparam bit FN_RD  = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // func, reader_id, data_in, key_frame, frame_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;      // status, data_out, out_frame_length, out_key,
                               // out_frame_number
  logic        out_tlast;

  keyframe_ring_frame_buffer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    kfrb_pkg::status_t st;
    bit [7:0]    data;
    bit [20:0]   flen;
    bit          key;
    bit [31:0]   fnum;
    bit          last;
  } result_t;

  typedef struct {
    bit                fixed;
    kfrb_pkg::status_t st;
    bit                last;
  } pin_t;

  result_t expected_q[$];
  pin_t    pin_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      snd_idle = 0;
  int      rcv_stall = 0;

  // ring model
  bit [7:0]    ring_mem [int];
  bit          tag_head [NSLOT];
  bit          tag_key  [NSLOT];
  int unsigned tag_fnum [NSLOT];
  int unsigned tag_flen [NSLOT];
  int unsigned tag_plen [NSLOT];
  int unsigned pub_slot, work_slot, key_pos, frame_cnt;
  bit          key_ok;
  bit          w_act, w_key;
  kfrb_pkg::wmode_t w_mode;
  int unsigned w_len, w_cnt, w_head, w_off;
  int unsigned r_slot [NREAD];
  bit          r_valid [NREAD];
  int unsigned r_lastf [NREAD];
  bit          r_act [NREAD];
  bit          r_key [NREAD];
  int unsigned r_len [NREAD], r_cnt [NREAD], r_off [NREAD];

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tag_head[i] = 0; tag_key[i] = 0; tag_fnum[i] = 0; tag_flen[i] = 0; tag_plen[i] = 0;
    end
    pub_slot = 0; work_slot = 0; key_pos = 0; frame_cnt = 0; key_ok = 0;
    w_act = 0; w_key = 0; w_mode = kfrb_pkg::WM_STORE;
    w_len = 0; w_cnt = 0; w_head = 0; w_off = 0;
    for (int i = 0; i < NREAD; i++) begin
      r_slot[i] = 0; r_valid[i] = 0; r_lastf[i] = 0; r_act[i] = 0; r_key[i] = 0;
      r_len[i] = 0; r_cnt[i] = 0; r_off[i] = 0;
    end
  end

  function automatic result_t ring_step(logic [39:0] td);
    result_t     r;
    bit          f;
    int unsigned rid, s, rem, fl;
    f   = td[0];
    rid = td[2:1];
    fl  = td[32:12];
    r = '{st: kfrb_pkg::ST_STORED, data: 8'h00, flen: 21'd0, key: 1'b0, fnum: 32'd0,
          last: 1'b0};
    if (f == FN_WR) begin
      if (!w_act) begin
        if (fl == 0) begin
          r.st = kfrb_pkg::ST_REJECTED; r.last = 1;
          return r;
        end
        w_len = fl; w_cnt = 0; w_key = td[11]; w_head = work_slot; w_off = 0;
        if (fl > NSLOT * NBYTE) w_mode = kfrb_pkg::WM_REJECT;
        else if (!w_key && !key_ok) w_mode = kfrb_pkg::WM_DROP;
        else w_mode = kfrb_pkg::WM_STORE;
        w_act = 1;
      end
      if (w_mode != kfrb_pkg::WM_STORE) begin
        w_cnt++;
        r.st = (w_mode == kfrb_pkg::WM_REJECT) ? kfrb_pkg::ST_REJECTED
                                               : kfrb_pkg::ST_DROPPED;
        if (w_cnt >= w_len) begin
          w_act = 0; r.last = 1;
        end
        return r;
      end
      s = work_slot % NSLOT;
      if (w_off == 0) begin
        rem = w_len - w_cnt;
        tag_head[s] = (w_cnt == 0);
        if (w_cnt == 0) tag_key[s] = w_key;
        tag_fnum[s] = frame_cnt;
        tag_flen[s] = w_len;
        tag_plen[s] = (rem < NBYTE) ? rem : NBYTE;
      end
      ring_mem[s * NBYTE + (w_off % NBYTE)] = td[10:3];
      w_off++; w_cnt++;
      r.st = kfrb_pkg::ST_STORED;
      if (w_off >= NBYTE || w_cnt >= w_len) begin
        work_slot = (s + 1) % NSLOT; w_off = 0;
      end
      if (w_cnt >= w_len) begin
        pub_slot = work_slot;
        if (w_key) begin
          key_pos = w_head; key_ok = 1;
        end
        frame_cnt++;
        w_act = 0; r.last = 1;
      end
      return r;
    end
    if (rid >= NREAD) begin
      r.st = kfrb_pkg::ST_EMPTY;
      return r;
    end
    if (!r_act[rid]) begin
      if (!key_ok || (r_valid[rid] && r_slot[rid] == pub_slot)) begin
        r.st = kfrb_pkg::ST_EMPTY;
        return r;
      end
      s = r_slot[rid] % NSLOT;
      // resync on first use or on a break in the frame sequence
      if (!r_valid[rid] || r_lastf[rid] + 1 != tag_fnum[s]) begin
        r_slot[rid] = key_pos % NSLOT; r_valid[rid] = 1;
      end
      s = r_slot[rid] % NSLOT;
      r_len[rid] = tag_flen[s]; r_key[rid] = tag_key[s]; r_lastf[rid] = tag_fnum[s];
      r_cnt[rid] = 0; r_off[rid] = 0; r_act[rid] = 1;
    end
    s = r_slot[rid] % NSLOT;
    r.st   = kfrb_pkg::ST_READ;
    r.data = ring_mem.exists(s * NBYTE + r_off[rid]) ? ring_mem[s * NBYTE + r_off[rid]] : 8'h00;
    r.flen = r_len[rid][20:0];
    r.key  = r_key[rid];
    r.fnum = r_lastf[rid];
    r_off[rid]++; r_cnt[rid]++;
    if (r_off[rid] >= tag_plen[s] || r_off[rid] >= NBYTE || r_cnt[rid] >= r_len[rid]) begin
      r_slot[rid] = (s + 1) % NSLOT; r_off[rid] = 0;
    end
    if (r_cnt[rid] >= r_len[rid]) begin
      r_act[rid] = 0; r.last = 1;
    end
    return r;
  endfunction

  // monitor: results are checked before the same edge's input is predicted
  always @(posedge clk) begin
    result_t e, p;
    pin_t    o;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[2:0] !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_tdata[2:0]); errors++;
        end
        if (out_tdata[10:3] !== e.data) begin
          $error("data_out exp %0h got %0h", e.data, out_tdata[10:3]); errors++;
        end
        if (out_tdata[31:11] !== e.flen) begin
          $error("out_frame_length exp %0d got %0d", e.flen, out_tdata[31:11]); errors++;
        end
        if (out_tdata[32] !== e.key) begin
          $error("out_key exp %0d got %0d", e.key, out_tdata[32]); errors++;
        end
        if (out_tdata[64:33] !== e.fnum) begin
          $error("out_frame_number exp %0d got %0d", e.fnum, out_tdata[64:33]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      p = ring_step(in_tdata);
      o = pin_q.pop_front();
      if (o.fixed) p = '{st: o.st, data: 8'h00, flen: 21'd0, key: 1'b0, fnum: 32'd0,
                         last: o.last};
      expected_q.push_back(p);
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(bit f, bit [1:0] rid, bit [7:0] d, bit k, bit [20:0] fl,
                           bit fixed = 1'b0,
                           kfrb_pkg::status_t st = kfrb_pkg::ST_STORED,
                           bit lst = 1'b0);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_q.push_back('{fixed: fixed, st: st, last: lst});
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, fl, k, d, rid, f};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  typedef struct {
    bit f; bit [1:0] rid; bit [7:0] d; bit k; bit [20:0] fl;
    bit fixed; kfrb_pkg::status_t st; bit lst;
  } row_t;

  row_t plan [] = '{
    '{FN_RD, 2'd0, 8'h00, 1'b0, 21'd0, 1'b1, kfrb_pkg::ST_EMPTY, 1'b0},
    '{FN_RD, 2'd3, 8'h00, 1'b0, 21'd0, 1'b1, kfrb_pkg::ST_EMPTY, 1'b0},
    '{FN_WR, 2'd0, 8'h00, 1'b1, 21'd0, 1'b1, kfrb_pkg::ST_REJECTED, 1'b1},
    '{FN_WR, 2'd0, 8'hFF, 1'b0, 21'd2, 1'b1, kfrb_pkg::ST_DROPPED, 1'b0},
    '{FN_WR, 2'd0, 8'h11, 1'b1, 21'd9, 1'b1, kfrb_pkg::ST_DROPPED, 1'b1},
    '{FN_WR, 2'd3, 8'h00, 1'b1, 21'd3, 1'b1, kfrb_pkg::ST_STORED, 1'b0},
    '{FN_WR, 2'd0, 8'hFF, 1'b0, 21'h1FFFFF, 1'b1, kfrb_pkg::ST_STORED, 1'b0},
    '{FN_WR, 2'd0, 8'h5A, 1'b0, 21'd0, 1'b1, kfrb_pkg::ST_STORED, 1'b1},
    '{FN_RD, 2'd0, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd0, 8'hFF, 1'b1, 21'h1FFFFF, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd0, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd0, 8'h00, 1'b0, 21'd0, 1'b1, kfrb_pkg::ST_EMPTY, 1'b0},
    '{FN_WR, 2'd0, 8'hA5, 1'b0, 21'd1, 1'b0, kfrb_pkg::ST_STORED, 1'b0},
    '{FN_RD, 2'd0, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd1, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd2, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0},
    '{FN_RD, 2'd3, 8'h00, 1'b0, 21'd0, 1'b0, kfrb_pkg::ST_READ, 1'b0}
  };

  initial begin
    int          sent;
    int unsigned left;
    bit [20:0]   fl;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i])
      send_byte(plan[i].f, plan[i].rid, plan[i].d, plan[i].k, plan[i].fl,
                plan[i].fixed, plan[i].st, plan[i].lst);
    drain();
    left = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 55; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 55; end
        default: begin snd_idle = 7; rcv_stall = 7; end
      endcase
      sent = 0;
      while (sent < 165 || left != 0) begin
        if (left != 0 && $urandom_range(99) < 55) begin
          // mid-frame key and length are ignored, so they carry noise
          send_byte(FN_WR, 2'($urandom), 8'($urandom), 1'($urandom), 21'($urandom));
          left--;
        end else if (left == 0 && $urandom_range(99) < 40) begin
          case ($urandom_range(39))
            0:       fl = '0;
            1:       fl = 21'($urandom_range(90, 41));
            default: fl = 21'($urandom_range(40, 1));
          endcase
          send_byte(FN_WR, 2'($urandom), 8'($urandom), ($urandom_range(99) < 35), fl);
          left = (fl == 0) ? 0 : fl - 1;
        end else begin
          send_byte(FN_RD, 2'($urandom), 8'($urandom), 1'($urandom), 21'($urandom));
        end
        sent++;
      end
      drain();
    end
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
